// ===== rtl/koq_pkg.sv =====
// Shared types and codes of the keyed ordered queue.
// No dependencies; every other file imports this package.
package koq_pkg;

   // Command codes on the request channel
   localparam logic [2:0] CMD_PUSH   = 3'd0;
   localparam logic [2:0] CMD_POP    = 3'd1;
   localparam logic [2:0] CMD_PEEK   = 3'd2;
   localparam logic [2:0] CMD_REMOVE = 3'd3;
   localparam logic [2:0] CMD_MOVE   = 3'd4;
   localparam logic [2:0] CMD_CLEAR  = 3'd5;

   // Move directions (two bit signed)
   localparam logic [1:0] DIR_UP   = 2'b01;
   localparam logic [1:0] DIR_DOWN = 2'b11;

   // Result status codes
   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_INVALID   = 2'd1;
   localparam logic [1:0] ST_FULL      = 2'd2;
   localparam logic [1:0] ST_NOT_FOUND = 2'd3;

   // Fixed field widths
   localparam int CMD_BITS = 3;
   localparam int POS_BITS = 6;
   localparam int DIR_BITS = 2;
   localparam int STATUS_BITS = 2;
   localparam int CAP_BITS = 7;
   localparam logic [CAP_BITS-1:0] CAP_RESET = 7'd64;

   // Depth of the queue between front and back
   localparam int QDEPTH = 2;

   // Classified operation handed from front to back
   typedef enum logic [2:0] {
      OP_PUSH,
      OP_POP,
      OP_PEEK,
      OP_REMOVE,
      OP_MOVE,
      OP_CLEAR,
      OP_INVALID
   } op_type;

   typedef struct packed {
      op_type                 op;
      logic                   dir_up;
      logic [POS_BITS-1:0]    pos;
   } ctl_type;

endpackage

// ===== rtl/koq_req_if.sv =====
// Request channel of the keyed ordered queue: valid, ready and one command.
// Depends on koq_pkg for the fixed field widths.
interface koq_req_if
   import koq_pkg::*;
#(
   parameter int KEY_BITS = 32,
   parameter int PAYLOAD_BITS = 32
);
   logic                          valid;
   logic                          ready;
   logic [CMD_BITS-1:0]           cmd;
   logic [KEY_BITS-1:0]           key;
   logic [PAYLOAD_BITS-1:0]       entry_payload;
   logic [POS_BITS-1:0]           position;
   logic signed [DIR_BITS-1:0]    direction;

   modport source (output valid, cmd, key, entry_payload, position, direction, input ready);
   modport sink (input valid, cmd, key, entry_payload, position, direction, output ready);
endinterface

// ===== rtl/koq_rsp_if.sv =====
// Result channel of the keyed ordered queue: valid, ready and one result.
// Depends on koq_pkg for the fixed field widths.
interface koq_rsp_if
   import koq_pkg::*;
#(
   parameter int KEY_BITS = 32,
   parameter int PAYLOAD_BITS = 32,
   parameter int LEN_BITS = 7
);
   logic                          valid;
   logic                          ready;
   logic [STATUS_BITS-1:0]        status;
   logic [KEY_BITS-1:0]           out_key;
   logic [PAYLOAD_BITS-1:0]       out_payload;
   logic [LEN_BITS-1:0]           length;

   modport source (output valid, status, out_key, out_payload, length, input ready);
   modport sink (input valid, status, out_key, out_payload, length, output ready);
endinterface

// ===== rtl/koq_front.sv =====
// Front end: takes requests, classifies them and queues them for the back end.
// Depends on koq_pkg and koq_req_if.
module koq_front
   import koq_pkg::*;
#(
   parameter int KEY_BITS = 32,
   parameter int PAYLOAD_BITS = 32
) (
   input  logic                    clock,
   input  logic                    reset,
   koq_req_if.sink                 req_ch,
   output logic                    q_valid,
   input  logic                    q_ready,
   output ctl_type                 q_ctl,
   output logic [KEY_BITS-1:0]     q_key,
   output logic [PAYLOAD_BITS-1:0] q_payload
);

   localparam int QP_BITS = $clog2(QDEPTH);
   localparam int QC_BITS = $clog2(QDEPTH + 1);

   ctl_type                 ctl_ff [QDEPTH];
   logic [KEY_BITS-1:0]     key_ff [QDEPTH];
   logic [PAYLOAD_BITS-1:0] pay_ff [QDEPTH];
   logic [QP_BITS-1:0]      wp_ff, wp_in, rp_ff, rp_in;
   logic [QC_BITS-1:0]      cnt_ff, cnt_in;
   ctl_type                 cls;
   logic                    push, pop;

   // Classify the command, folding every bad argument into one invalid op
   always_comb begin
      cls.pos = req_ch.position;
      cls.dir_up = (req_ch.direction == DIR_UP);
      unique case (req_ch.cmd)
         CMD_PUSH:   cls.op = OP_PUSH;
         CMD_POP:    cls.op = OP_POP;
         CMD_PEEK:   cls.op = OP_PEEK;
         CMD_REMOVE: cls.op = (req_ch.key == '0) ? OP_INVALID : OP_REMOVE;
         CMD_MOVE: begin
            if (req_ch.key == '0 ||
                (req_ch.direction != DIR_UP && req_ch.direction != DIR_DOWN)) begin
               cls.op = OP_INVALID;
            end else begin
               cls.op = OP_MOVE;
            end
         end
         CMD_CLEAR:  cls.op = OP_CLEAR;
         default:    cls.op = OP_INVALID;
      endcase
   end

   assign req_ch.ready = (cnt_ff < QC_BITS'(QDEPTH));
   assign push = req_ch.valid && req_ch.ready;
   assign pop = q_valid && q_ready;

   assign q_valid = (cnt_ff != '0);
   assign q_ctl = ctl_ff[rp_ff];
   assign q_key = key_ff[rp_ff];
   assign q_payload = pay_ff[rp_ff];

   // Advance pointers and occupancy
   always_comb begin
      wp_in = push ? QP_BITS'(wp_ff + 1'b1) : wp_ff;
      rp_in = pop ? QP_BITS'(rp_ff + 1'b1) : rp_ff;
      cnt_in = cnt_ff;
      if (push && !pop) begin
         cnt_in = QC_BITS'(cnt_ff + 1'b1);
      end else if (pop && !push) begin
         cnt_in = QC_BITS'(cnt_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= '0;
         rp_ff <= '0;
         cnt_ff <= '0;
      end else begin
         wp_ff <= wp_in;
         rp_ff <= rp_in;
         cnt_ff <= cnt_in;
      end
   end

   // Store the classified item
   always_ff @(posedge clock) begin
      if (push) begin
         ctl_ff[wp_ff] <= cls;
         key_ff[wp_ff] <= req_ch.key;
         pay_ff[wp_ff] <= req_ch.entry_payload;
      end
   end

endmodule

// ===== rtl/koq_back.sv =====
// Back end: executes queued commands on the entry memory and registers results.
// Depends on koq_pkg and koq_rsp_if.
module koq_back
   import koq_pkg::*;
#(
   parameter int DEPTH = 64,
   parameter int KEY_BITS = 32,
   parameter int PAYLOAD_BITS = 32
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic [CAP_BITS-1:0]     capacity,
   input  logic                    q_valid,
   output logic                    q_ready,
   input  ctl_type                 q_ctl,
   input  logic [KEY_BITS-1:0]     q_key,
   input  logic [PAYLOAD_BITS-1:0] q_payload,
   koq_rsp_if.source               rsp_ch
);

   localparam int IDX_BITS = $clog2(DEPTH);
   localparam int CNT_BITS = $clog2(DEPTH + 1);
   localparam int CMP_BITS = CNT_BITS + CAP_BITS;
   localparam int DW = KEY_BITS + PAYLOAD_BITS;

   typedef enum logic [5:0] {
      S_IDLE   = 6'b000001,
      S_SEARCH = 6'b000010,
      S_CAP    = 6'b000100,
      S_SHIFT  = 6'b001000,
      S_SWAP1  = 6'b010000,
      S_SWAP2  = 6'b100000
   } state_type;

   state_type               state_ff, state_in;
   logic [DW-1:0]           mem [DEPTH];
   logic [DW-1:0]           rd_data_ff;
   logic [IDX_BITS-1:0]     rd_addr, wr_addr;
   logic [DW-1:0]           wr_data;
   logic                    wr_en;

   op_type                  op_ff, op_in;
   logic [KEY_BITS-1:0]     key_ff, key_in;
   logic                    dir_up_ff, dir_up_in;
   logic [CNT_BITS-1:0]     count_ff, count_in;
   logic [CNT_BITS-1:0]     ptr_ff, ptr_in, src_ff, src_in, dst_ff, dst_in;
   logic [CNT_BITS-1:0]     idx_ff, idx_in, tgt_ff, tgt_in;
   logic                    chk_ff, chk_in, pend_ff, pend_in;
   logic [DW-1:0]           tmp_ff, tmp_in;
   logic [KEY_BITS-1:0]     cap_key_ff, cap_key_in;
   logic [PAYLOAD_BITS-1:0] cap_pay_ff, cap_pay_in;

   logic                    rsp_valid_ff, rsp_valid_in;
   logic [STATUS_BITS-1:0]  status_ff, status_in;
   logic [KEY_BITS-1:0]     okey_ff, okey_in;
   logic [PAYLOAD_BITS-1:0] opay_ff, opay_in;
   logic [CNT_BITS-1:0]     len_ff;

   logic                    full, issue, match, dispatch;
   logic [CNT_BITS-1:0]     found, tgt;

   assign rsp_ch.valid = rsp_valid_ff;
   assign rsp_ch.status = status_ff;
   assign rsp_ch.out_key = okey_ff;
   assign rsp_ch.out_payload = opay_ff;
   assign rsp_ch.length = len_ff;

   assign q_ready = (state_ff == S_IDLE) && !rsp_valid_ff;
   assign dispatch = q_valid && q_ready;

   assign full = (count_ff == CNT_BITS'(DEPTH)) ||
                 (CMP_BITS'(count_ff) >= CMP_BITS'(capacity));
   assign match = chk_ff && (rd_data_ff[DW-1:PAYLOAD_BITS] == key_ff);
   assign found = CNT_BITS'(ptr_ff - 1'b1);

   // Neighbour of the found entry, clamped at the ends
   always_comb begin
      if (dir_up_ff) begin
         tgt = (CNT_BITS'(found + 1'b1) >= count_ff) ? found : CNT_BITS'(found + 1'b1);
      end else begin
         tgt = (found == '0) ? found : CNT_BITS'(found - 1'b1);
      end
   end

   // Sequencer
   always_comb begin
      state_in = state_ff;
      op_in = op_ff;
      key_in = key_ff;
      dir_up_in = dir_up_ff;
      count_in = count_ff;
      ptr_in = ptr_ff;
      chk_in = chk_ff;
      src_in = src_ff;
      dst_in = dst_ff;
      pend_in = pend_ff;
      idx_in = idx_ff;
      tgt_in = tgt_ff;
      tmp_in = tmp_ff;
      cap_key_in = cap_key_ff;
      cap_pay_in = cap_pay_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      status_in = status_ff;
      okey_in = okey_ff;
      opay_in = opay_ff;
      rd_addr = '0;
      wr_en = 1'b0;
      wr_addr = '0;
      wr_data = '0;
      issue = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (dispatch) begin
               op_in = q_ctl.op;
               key_in = q_key;
               dir_up_in = q_ctl.dir_up;
               ptr_in = '0;
               chk_in = 1'b0;
               cap_key_in = '0;
               cap_pay_in = '0;
               okey_in = '0;
               opay_in = '0;
               status_in = ST_OK;
               unique case (q_ctl.op)
                  OP_PUSH: begin
                     rsp_valid_in = 1'b1;
                     if (full) begin
                        status_in = ST_FULL;
                     end else begin
                        wr_en = 1'b1;
                        wr_addr = IDX_BITS'(count_ff);
                        wr_data = {q_key, q_payload};
                        count_in = CNT_BITS'(count_ff + 1'b1);
                     end
                  end
                  OP_POP: begin
                     if (count_ff == '0) begin
                        rsp_valid_in = 1'b1;
                        status_in = ST_NOT_FOUND;
                     end else begin
                        rd_addr = '0;
                        state_in = S_CAP;
                     end
                  end
                  OP_PEEK: begin
                     if (CMP_BITS'(q_ctl.pos) >= CMP_BITS'(count_ff)) begin
                        rsp_valid_in = 1'b1;
                        status_in = ST_NOT_FOUND;
                     end else begin
                        rd_addr = IDX_BITS'(q_ctl.pos);
                        state_in = S_CAP;
                     end
                  end
                  OP_REMOVE, OP_MOVE: state_in = S_SEARCH;
                  OP_CLEAR: begin
                     count_in = '0;
                     rsp_valid_in = 1'b1;
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                     status_in = ST_INVALID;
                  end
               endcase
            end
         end
         S_SEARCH: begin
            // Read one entry per cycle, compare the one read the cycle before
            issue = (ptr_ff < count_ff);
            rd_addr = IDX_BITS'(ptr_ff);
            if (match) begin
               idx_in = found;
               tmp_in = rd_data_ff;
               if (op_ff == OP_REMOVE) begin
                  src_in = CNT_BITS'(found + 1'b1);
                  dst_in = found;
                  pend_in = 1'b0;
                  state_in = S_SHIFT;
               end else if (tgt == found) begin
                  rsp_valid_in = 1'b1;
                  status_in = ST_OK;
                  state_in = S_IDLE;
               end else begin
                  rd_addr = IDX_BITS'(tgt);
                  tgt_in = tgt;
                  state_in = S_SWAP1;
               end
            end else if (!chk_ff && !issue) begin
               rsp_valid_in = 1'b1;
               status_in = ST_NOT_FOUND;
               state_in = S_IDLE;
            end else begin
               ptr_in = issue ? CNT_BITS'(ptr_ff + 1'b1) : ptr_ff;
               chk_in = issue;
            end
         end
         S_CAP: begin
            if (op_ff == OP_PEEK) begin
               rsp_valid_in = 1'b1;
               status_in = ST_OK;
               okey_in = rd_data_ff[DW-1:PAYLOAD_BITS];
               opay_in = rd_data_ff[PAYLOAD_BITS-1:0];
               state_in = S_IDLE;
            end else begin
               cap_key_in = rd_data_ff[DW-1:PAYLOAD_BITS];
               cap_pay_in = rd_data_ff[PAYLOAD_BITS-1:0];
               src_in = CNT_BITS'(1);
               dst_in = '0;
               pend_in = 1'b0;
               state_in = S_SHIFT;
            end
         end
         S_SHIFT: begin
            // Move each later entry down by one place, read and write overlapped
            issue = (src_ff < count_ff);
            rd_addr = IDX_BITS'(src_ff);
            src_in = issue ? CNT_BITS'(src_ff + 1'b1) : src_ff;
            pend_in = issue;
            if (pend_ff) begin
               wr_en = 1'b1;
               wr_addr = IDX_BITS'(dst_ff);
               wr_data = rd_data_ff;
               dst_in = CNT_BITS'(dst_ff + 1'b1);
            end
            if (!pend_ff && !issue) begin
               count_in = CNT_BITS'(count_ff - 1'b1);
               rsp_valid_in = 1'b1;
               status_in = ST_OK;
               okey_in = cap_key_ff;
               opay_in = cap_pay_ff;
               state_in = S_IDLE;
            end
         end
         S_SWAP1: begin
            wr_en = 1'b1;
            wr_addr = IDX_BITS'(idx_ff);
            wr_data = rd_data_ff;
            state_in = S_SWAP2;
         end
         S_SWAP2: begin
            wr_en = 1'b1;
            wr_addr = IDX_BITS'(tgt_ff);
            wr_data = tmp_ff;
            rsp_valid_in = 1'b1;
            status_in = ST_OK;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Entry memory: one write and one registered read a cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Working and result registers
   always_ff @(posedge clock) begin
      op_ff <= op_in;
      key_ff <= key_in;
      dir_up_ff <= dir_up_in;
      ptr_ff <= ptr_in;
      chk_ff <= chk_in;
      src_ff <= src_in;
      dst_ff <= dst_in;
      pend_ff <= pend_in;
      idx_ff <= idx_in;
      tgt_ff <= tgt_in;
      tmp_ff <= tmp_in;
      cap_key_ff <= cap_key_in;
      cap_pay_ff <= cap_pay_in;
      status_ff <= status_in;
      okey_ff <= okey_in;
      opay_ff <= opay_in;
      if (rsp_valid_in && !(rsp_valid_ff && !rsp_ch.ready)) begin
         len_ff <= count_in;
      end
   end

endmodule

// ===== rtl/keyed_ordered_queue.sv =====
// Keyed ordered queue top level: capacity register, front end and back end.
// Depends on koq_pkg, koq_req_if, koq_rsp_if, koq_front and koq_back.
// Push, clear, rejected commands and misses of pop and peek answer without a memory
// read; a peek hit reads one entry; pop, remove and move read the entry memory once
// per entry searched or shifted.
// One command at a time in the back end, next one after the result transfer.
// Reset (synchronous) empties the queue and sets capacity to 64; entries are not cleared.
module keyed_ordered_queue
   import koq_pkg::*;
#(
   parameter int DEPTH = 64,
   parameter int KEY_BITS = 32,
   parameter int PAYLOAD_BITS = 32
) (
   input  logic                clock,
   input  logic                reset,
   koq_req_if.sink             req_ch,
   koq_rsp_if.source           rsp_ch,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [CAP_BITS-1:0] csr_data
);

   logic [CAP_BITS-1:0]     capacity_ff;
   logic                    q_valid, q_ready;
   ctl_type                 q_ctl;
   logic [KEY_BITS-1:0]     q_key;
   logic [PAYLOAD_BITS-1:0] q_payload;

   // Capacity register, always writable
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= CAP_RESET;
      end else if (csr_valid) begin
         capacity_ff <= csr_data;
      end
   end

   koq_front #(.KEY_BITS(KEY_BITS), .PAYLOAD_BITS(PAYLOAD_BITS)) u_front (
      .clock(clock), .reset(reset), .req_ch(req_ch),
      .q_valid(q_valid), .q_ready(q_ready), .q_ctl(q_ctl),
      .q_key(q_key), .q_payload(q_payload)
   );

   koq_back #(.DEPTH(DEPTH), .KEY_BITS(KEY_BITS), .PAYLOAD_BITS(PAYLOAD_BITS)) u_back (
      .clock(clock), .reset(reset), .capacity(capacity_ff),
      .q_valid(q_valid), .q_ready(q_ready), .q_ctl(q_ctl),
      .q_key(q_key), .q_payload(q_payload), .rsp_ch(rsp_ch)
   );

endmodule

// ===== rtl/koq_checker.sv =====
// Port-level checks of the keyed ordered queue, bound to the top level.
// Depends on koq_pkg and keyed_ordered_queue.
module koq_checker
   import koq_pkg::*;
#(
   parameter int DEPTH = 64,
   parameter int KEY_BITS = 32,
   parameter int PAYLOAD_BITS = 32
) (
   input logic                          clock,
   input logic                          reset,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [STATUS_BITS-1:0]        rsp_status,
   input logic [KEY_BITS-1:0]           rsp_key,
   input logic [PAYLOAD_BITS-1:0]       rsp_payload,
   input logic [$clog2(DEPTH+1)-1:0]    rsp_length,
   input logic                          csr_ready
);

   // A stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) && $stable(rsp_length))
      else $error("stalled result changed");

   // Length never exceeds the store
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_length <= DEPTH)
      else $error("length beyond depth");

   // Failed commands carry no entry
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_OK |-> rsp_key == '0 && rsp_payload == '0)
      else $error("entry data on failed command");

   // A stalled result keeps its entry data
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_key) && $stable(rsp_payload))
      else $error("stalled entry data changed");

   // Configuration is never stalled
   assert property (@(posedge clock) disable iff (reset) csr_ready)
      else $error("configuration stalled");

endmodule

bind keyed_ordered_queue koq_checker #(
   .DEPTH(DEPTH), .KEY_BITS(KEY_BITS), .PAYLOAD_BITS(PAYLOAD_BITS)
) u_koq_checker (
   .clock(clock), .reset(reset),
   .rsp_valid(rsp_ch.valid), .rsp_ready(rsp_ch.ready),
   .rsp_status(rsp_ch.status), .rsp_key(rsp_ch.out_key),
   .rsp_payload(rsp_ch.out_payload), .rsp_length(rsp_ch.length),
   .csr_ready(csr_ready)
);

// ===== test/koq_scoreboard.sv =====
// Scoreboard of the keyed ordered queue testbench: predicts each result from
// the accepted commands and checks the block's results. Depends on koq_pkg.
`timescale 1ns / 1ps

import koq_pkg::*;

class koq_scoreboard;

   typedef struct packed {
      logic [1:0]  status;
      logic [31:0] out_key;
      logic [31:0] out_payload;
      logic [6:0]  length;
   } outcome_type;

   logic [31:0] held_key[64];
   logic [31:0] held_pay[64];
   int unsigned held_count;
   int unsigned capacity;
   outcome_type pending[$];
   int unsigned errors;

   function new();
      held_count = 0;
      capacity = 64;
      errors = 0;
   endfunction

   function void set_capacity(logic [6:0] value);
      capacity = 32'(value);
   endfunction

   function int find_key(logic [31:0] k);
      for (int i = 0; i < held_count; i++)
         if (held_key[i] == k) return i;
      return -1;
   endfunction

   function void drop_at(int idx);
      for (int j = idx; j + 1 < held_count; j++) begin
         held_key[j] = held_key[j+1];
         held_pay[j] = held_pay[j+1];
      end
      held_count--;
   endfunction

   // Apply one accepted command and queue its outcome
   function void note_command(logic [2:0] cmd, logic [31:0] k, logic [31:0] p,
                              logic [5:0] pos, logic [1:0] dir);
      outcome_type o;
      int unsigned cap;
      int idx, tgt;
      logic [31:0] tk, tp;
      cap = capacity > 64 ? 64 : capacity;
      o = '0;
      o.status = ST_OK;
      case (cmd)
         CMD_PUSH: begin
            if (held_count >= cap) o.status = ST_FULL;
            else begin
               held_key[held_count] = k;
               held_pay[held_count] = p;
               held_count++;
            end
         end
         CMD_POP: begin
            if (held_count == 0) o.status = ST_NOT_FOUND;
            else begin
               o.out_key = held_key[0];
               o.out_payload = held_pay[0];
               drop_at(0);
            end
         end
         CMD_PEEK: begin
            if (pos >= held_count) o.status = ST_NOT_FOUND;
            else begin
               o.out_key = held_key[pos];
               o.out_payload = held_pay[pos];
            end
         end
         CMD_REMOVE: begin
            if (k == 0) o.status = ST_INVALID;
            else begin
               idx = find_key(k);
               if (idx < 0) o.status = ST_NOT_FOUND;
               else drop_at(idx);
            end
         end
         CMD_MOVE: begin
            if (k == 0 || (dir != DIR_UP && dir != DIR_DOWN)) o.status = ST_INVALID;
            else begin
               idx = find_key(k);
               if (idx < 0) o.status = ST_NOT_FOUND;
               else begin
                  if (dir == DIR_DOWN) tgt = idx == 0 ? 0 : idx - 1;
                  else tgt = (idx + 1 >= held_count) ? idx : idx + 1;
                  // swap with neighbour, clamped at the ends
                  tk = held_key[idx];
                  tp = held_pay[idx];
                  held_key[idx] = held_key[tgt];
                  held_pay[idx] = held_pay[tgt];
                  held_key[tgt] = tk;
                  held_pay[tgt] = tp;
               end
            end
         end
         CMD_CLEAR: held_count = 0;
         default: o.status = ST_INVALID;
      endcase
      o.length = 7'(held_count);
      pending.push_back(o);
   endfunction

   // Print one mismatch line and count it
   task report(string msg);
      $display("%s", msg);
      errors++;
   endtask

   // Compare one result transfer with the oldest prediction
   task check_result(logic [1:0] st, logic [31:0] k, logic [31:0] p, logic [6:0] len);
      outcome_type o;
      if (pending.size() == 0) begin
         report($sformatf("unexpected result: status %0d length %0d", st, len));
         return;
      end
      o = pending.pop_front();
      if (st !== o.status || k !== o.out_key || p !== o.out_payload || len !== o.length)
         report($sformatf({"result mismatch: got st %0d key %h pay %h len %0d, ",
                           "want st %0d key %h pay %h len %0d"},
                          st, k, p, len, o.status, o.out_key, o.out_payload, o.length));
   endtask
endclass

// ===== test/keyed_ordered_queue_test.sv =====
// Top of the keyed ordered queue testbench: clock, reset, stimulus, stalls.
// Depends on koq_pkg, koq_req_if, koq_rsp_if, koq_scoreboard and the RTL.
`timescale 1ns / 1ps

module keyed_ordered_queue_test;
   import koq_pkg::*;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [6:0] csr_data = '0;
   logic rsp_stall_mode = 1'b0;
   logic [31:0] key_pool[8];
   koq_scoreboard board = new();

   koq_req_if req_ch();
   koq_rsp_if rsp_ch();

   keyed_ordered_queue uut (
      .clock(clock), .reset(reset), .req_ch(req_ch.sink), .rsp_ch(rsp_ch.source),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   initial begin
      req_ch.valid = 1'b0;
      req_ch.cmd = '0;
      req_ch.key = '0;
      req_ch.entry_payload = '0;
      req_ch.position = '0;
      req_ch.direction = '0;
      rsp_ch.ready = 1'b0;
   end

   // Receiver: stall on a pattern that changes over the run
   always @(negedge clock) begin
      if (rsp_stall_mode) rsp_ch.ready <= ($urandom_range(0, 3) != 0);
      else rsp_ch.ready <= 1'b1;
   end

   // Check each result transfer
   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready)
         board.check_result(rsp_ch.status, rsp_ch.out_key, rsp_ch.out_payload, rsp_ch.length);
   end

   // Send one command; hold it until transfer
   task automatic send(logic [2:0] cmd, logic [31:0] k, logic [31:0] p,
                       logic [5:0] pos, logic [1:0] dir);
      req_ch.valid <= 1'b1;
      req_ch.cmd <= cmd;
      req_ch.key <= k;
      req_ch.entry_payload <= p;
      req_ch.position <= pos;
      req_ch.direction <= dir;
      do @(posedge clock); while (!req_ch.ready);
      board.note_command(cmd, k, p, pos, dir);
      @(negedge clock);
   endtask

   task automatic idle(int n);
      req_ch.valid <= 1'b0;
      repeat (n) @(negedge clock);
   endtask

   // Wait for every result, then settle before a register write
   task automatic drain();
      idle(1);
      while (board.pending.size() != 0) @(negedge clock);
      repeat (140) @(negedge clock);
   endtask

   task automatic write_capacity(logic [6:0] value);
      csr_valid <= 1'b1;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      board.set_capacity(value);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Random command, mostly on keys likely present
   task automatic random_command();
      int sel;
      logic [31:0] k;
      sel = $urandom_range(0, 99);
      k = ($urandom_range(0, 9) == 0) ? $urandom : key_pool[$urandom_range(0, 7)];
      if (sel < 35)
         send(CMD_PUSH, k, $urandom, 6'($urandom), 2'($urandom));
      else if (sel < 47)
         send(CMD_POP, $urandom, $urandom, 6'($urandom), 2'($urandom));
      else if (sel < 60)
         send(CMD_PEEK, $urandom, $urandom, 6'($urandom_range(0, 20)), 2'($urandom));
      else if (sel < 72)
         send(CMD_REMOVE, k, $urandom, 6'($urandom), 2'($urandom));
      else if (sel < 92)
         send(CMD_MOVE, k, $urandom, 6'($urandom),
              ($urandom_range(0, 9) == 0) ? 2'($urandom) :
              ($urandom_range(0, 1) ? DIR_UP : DIR_DOWN));
      else if (sel < 95)
         send(CMD_CLEAR, $urandom, $urandom, 6'($urandom), 2'($urandom));
      else if (sel < 97)
         send(3'd6 + 3'($urandom_range(0, 1)), $urandom, $urandom, 6'($urandom),
              2'($urandom));
      else
         send(CMD_PEEK, $urandom, $urandom, 6'($urandom), 2'($urandom));
   endtask

   initial begin
      logic [6:0] caps[6];
      caps = '{7'd0, 7'd127, 7'd3, 7'd64, 7'd65, 7'd12};
      foreach (key_pool[i]) key_pool[i] = $urandom;
      key_pool[0] = 32'hFFFF_FFFF;
      key_pool[1] = 32'h0000_0001;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      repeat (2) @(negedge clock);

      // Directed: extremes and each special case
      send(CMD_POP, 0, 0, 0, 0);
      send(CMD_PEEK, 0, 0, 0, 0);
      send(CMD_PUSH, 32'h0, 32'hFFFF_FFFF, 0, 0);
      send(CMD_PUSH, 32'hFFFF_FFFF, 32'h0, 6'h3F, 2'b11);
      send(CMD_PUSH, 32'h5, 32'hA5A5_5A5A, 0, 0);
      send(CMD_PUSH, 32'h5, 32'h1234_5678, 0, 0);
      send(CMD_PEEK, 0, 0, 6'd3, 0);
      send(CMD_PEEK, 0, 0, 6'd4, 0);
      send(CMD_PEEK, 0, 0, 6'h3F, 0);
      send(CMD_REMOVE, 0, 0, 0, 0);
      send(CMD_MOVE, 0, 0, 0, DIR_UP);
      send(CMD_MOVE, 32'h5, 0, 0, 2'b00);
      send(CMD_MOVE, 32'h5, 0, 0, 2'b10);
      send(CMD_MOVE, 32'h0, 0, 0, DIR_DOWN);
      send(CMD_MOVE, 32'h5, 0, 0, DIR_UP);
      send(CMD_MOVE, 32'h5, 0, 0, DIR_UP);
      send(CMD_MOVE, 32'hFFFF_FFFF, 0, 0, DIR_DOWN);
      send(CMD_MOVE, 32'h7777, 0, 0, DIR_UP);
      send(CMD_REMOVE, 32'h5, 0, 0, 0);
      send(CMD_REMOVE, 32'h7777, 0, 0, 0);
      send(3'd6, 0, 0, 0, 0);
      send(3'd7, 0, 0, 0, 0);
      send(CMD_POP, 0, 0, 0, 0);
      send(CMD_CLEAR, 0, 0, 0, 0);

      // Random phases across capacity settings
      foreach (caps[c]) begin
         drain();
         write_capacity(caps[c]);
         rsp_stall_mode <= c[0];
         for (int n = 0; n < 290; ) begin
            int burst;
            burst = $urandom_range(1, 12);
            for (int b = 0; b < burst && n < 290; b++, n++) random_command();
            if ($urandom_range(0, 3) != 0) idle($urandom_range(1, 20));
         end
         // Lower capacity below the count to show full after shrink
         if (c == 3) begin
            drain();
            write_capacity(7'd2);
            send(CMD_PUSH, 32'h9, 32'h9, 0, 0);
         end
      end

      idle(1);
      while (board.pending.size() != 0) @(negedge clock);
      repeat (200) @(negedge clock);
      if (board.errors == 0 && board.pending.size() == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

   initial begin
      #3000000;
      $display("*** FAILED ***");
      $finish;
   end
endmodule
